// ===== hw/rtl/bgfp_pkg.sv =====
// Shared types and constants for the binary GNSS frame parser.
// No dependencies; imported by all modules: skid buffer, core, checker, bench.
package bgfp_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hB5;
	localparam logic [7:0] SYNC_SECOND = 8'h62;
	localparam logic [7:0] TEXT_START  = 8'h24;
	localparam logic [7:0] TEXT_END    = 8'h0A;

	localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;
	localparam logic [7:0]  MAX_LINE_RESET    = 8'd128;

	// configuration register indexes
	localparam logic CFG_MAX_PAYLOAD = 1'b0;
	localparam logic CFG_MAX_LINE    = 1'b1;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_REPORT  = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_BAD_CK   = 2'd1;
	localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

	typedef enum logic [9:0] {
		PH_IDLE    = 10'b00_0000_0001,
		PH_LINE    = 10'b00_0000_0010,
		PH_SYNC2   = 10'b00_0000_0100,
		PH_CLASS   = 10'b00_0000_1000,
		PH_ID      = 10'b00_0001_0000,
		PH_LEN_LO  = 10'b00_0010_0000,
		PH_LEN_HI  = 10'b00_0100_0000,
		PH_PAYLOAD = 10'b00_1000_0000,
		PH_CK_A    = 10'b01_0000_0000,
		PH_CK_B    = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  msg_class;
		logic [7:0]  msg_id;
		logic [7:0]  data_byte;
		logic [15:0] byte_index;
		logic [15:0] frame_length;
		logic [1:0]  frame_status;
		logic        last;
	} result_t;

endpackage

// ===== hw/rtl/bgfp_out_skid.sv =====
// Two-entry output buffer (output register plus skid register) for parser results.
// Depends on bgfp_pkg for result_t.
module bgfp_out_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bgfp_pkg::result_t push_data,
	output logic              space,
	output logic              out_valid,
	input  logic              out_ready,
	output bgfp_pkg::result_t out_data
);
	import bgfp_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    pop;

	assign pop       = out_valid_q && out_ready;
	assign space     = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (!push) begin
				out_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			if (out_valid_q) begin
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end
	end

`ifndef SYNTHESIS
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without a valid output entry");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && out_ready) |=> (out_valid_q && !skid_valid_q))
		else $error("skid entry not moved to output after transfer");

	a_push_has_space: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> space)
		else $error("result pushed into a full buffer");
`endif

endmodule

// ===== hw/rtl/binary_gnss_frame_parser_core.sv =====
// Top level of the binary GNSS frame parser: phase tracking, Fletcher-8 checksum,
// configuration registers. Depends on bgfp_pkg and bgfp_out_skid.

// The parser takes one serial byte per transfer on rx_byte and can take a new
// byte in every clock cycle: each byte is decoded, checked against the running
// Fletcher-8 sums and folded into the phase state in the cycle of its transfer,
// and any result lands in a two-entry output buffer. Input ready drops only
// while both buffer entries hold results that the consumer has not taken,
// so a stall on the output side stops input after at most one more
// result-producing byte. In idle, '$' starts a text line that is dropped until
// newline or max_line_length characters; 0xB5 0x62 starts a binary frame of
// class, id, little-endian length, payload and two checksum bytes. Every
// payload byte is emitted at once with kind 0 and its index; it is tentative
// until the closing report (kind 1, last 1) gives status ok, bad checksum, or
// too long. A too-long length ends the frame right after the length bytes.
// Registers are written through cfg_we/cfg_index/cfg_data: index 0 is
// max_payload_length (reset 1024), index 1 is max_line_length (reset 128).
// Write them only while the parser is idle.
module binary_gnss_frame_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  msg_class,
	output logic [7:0]  msg_id,
	output logic [7:0]  data_byte,
	output logic [15:0] byte_index,
	output logic [15:0] frame_length,
	output logic [1:0]  frame_status,
	output logic        last
);
	import bgfp_pkg::*;

	// configuration
	logic [15:0] max_payload_q;
	logic [7:0]  max_line_q;

	// parse state
	phase_t      phase_q,  phase_d;
	logic [7:0]  line_q,   line_d;
	logic [7:0]  class_q,  class_d;
	logic [7:0]  id_q,     id_d;
	logic [15:0] length_q, length_d;
	logic [15:0] pos_q,    pos_d;
	logic [7:0]  sum_a_q,  sum_a_d;
	logic [7:0]  sum_b_q,  sum_b_d;
	logic [7:0]  ck_a_q,   ck_a_d;

	logic        accept;
	logic        space;
	logic        res_valid;
	result_t     res;
	result_t     out_data;

	logic [7:0]  sum_a_add;
	logic [7:0]  sum_b_add;
	logic [7:0]  line_inc;
	logic [15:0] pos_inc;
	logic [15:0] length_full;

	assign in_ready = space;
	assign accept   = in_valid && in_ready;

	// Fletcher-8 step: B takes the updated A
	assign sum_a_add   = sum_a_q + rx_byte;
	assign sum_b_add   = sum_b_q + sum_a_add;
	assign line_inc    = line_q + 8'd1;
	assign pos_inc     = pos_q + 16'd1;
	assign length_full = {rx_byte, length_q[7:0]};

	always_comb begin
		phase_d   = phase_q;
		line_d    = line_q;
		class_d   = class_q;
		id_d      = id_q;
		length_d  = length_q;
		pos_d     = pos_q;
		sum_a_d   = sum_a_q;
		sum_b_d   = sum_b_q;
		ck_a_d    = ck_a_q;
		res_valid = 1'b0;

		res.kind         = KIND_PAYLOAD;
		res.msg_class    = class_q;
		res.msg_id       = id_q;
		res.data_byte    = 8'd0;
		res.byte_index   = 16'd0;
		res.frame_length = length_q;
		res.frame_status = STATUS_OK;
		res.last         = 1'b0;

		case (phase_q)
			PH_LINE: begin
				if (rx_byte == TEXT_END) begin
					line_d  = 8'd0;
					phase_d = PH_IDLE;
				end else if (line_inc >= max_line_q || line_inc < 8'd2) begin
					line_d  = 8'd0;
					phase_d = PH_IDLE;
				end else begin
					line_d = line_inc;
				end
			end
			PH_SYNC2: begin
				if (rx_byte == SYNC_SECOND) begin
					sum_a_d = 8'd0;
					sum_b_d = 8'd0;
					phase_d = PH_CLASS;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_CLASS: begin
				class_d = rx_byte;
				sum_a_d = sum_a_add;
				sum_b_d = sum_b_add;
				phase_d = PH_ID;
			end
			PH_ID: begin
				id_d    = rx_byte;
				sum_a_d = sum_a_add;
				sum_b_d = sum_b_add;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				length_d = {8'd0, rx_byte};
				sum_a_d  = sum_a_add;
				sum_b_d  = sum_b_add;
				phase_d  = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				length_d = length_full;
				sum_a_d  = sum_a_add;
				sum_b_d  = sum_b_add;
				pos_d    = 16'd0;
				if (length_full > max_payload_q) begin
					// abandon the frame and report it as too long
					res_valid        = 1'b1;
					res.kind         = KIND_REPORT;
					res.frame_length = length_full;
					res.frame_status = STATUS_TOO_LONG;
					res.last         = 1'b1;
					phase_d          = PH_IDLE;
				end else if (length_full == 16'd0) begin
					phase_d = PH_CK_A;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				res_valid      = 1'b1;
				res.data_byte  = rx_byte;
				res.byte_index = pos_q;
				sum_a_d        = sum_a_add;
				sum_b_d        = sum_b_add;
				pos_d          = pos_inc;
				if (pos_inc >= length_q) begin
					phase_d = PH_CK_A;
				end
			end
			PH_CK_A: begin
				ck_a_d  = rx_byte;
				phase_d = PH_CK_B;
			end
			PH_CK_B: begin
				res_valid        = 1'b1;
				res.kind         = KIND_REPORT;
				res.last         = 1'b1;
				res.frame_status = (ck_a_q == sum_a_q && rx_byte == sum_b_q) ?
					STATUS_OK : STATUS_BAD_CK;
				phase_d          = PH_IDLE;
			end
			default: begin
				// idle and any stray code: look for a line or frame start
				phase_d = PH_IDLE;
				if (rx_byte == TEXT_START) begin
					line_d  = 8'd1;
					phase_d = PH_LINE;
				end else if (rx_byte == SYNC_FIRST) begin
					phase_d = PH_SYNC2;
				end
			end
		endcase
	end

	// advance parse state on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			line_q   <= 8'd0;
			class_q  <= 8'd0;
			id_q     <= 8'd0;
			length_q <= 16'd0;
			pos_q    <= 16'd0;
			sum_a_q  <= 8'd0;
			sum_b_q  <= 8'd0;
			ck_a_q   <= 8'd0;
		end else if (accept) begin
			phase_q  <= phase_d;
			line_q   <= line_d;
			class_q  <= class_d;
			id_q     <= id_d;
			length_q <= length_d;
			pos_q    <= pos_d;
			sum_a_q  <= sum_a_d;
			sum_b_q  <= sum_b_d;
			ck_a_q   <= ck_a_d;
		end
	end

	// configuration writes are registered and apply from the next byte on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RESET;
			max_line_q    <= MAX_LINE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_PAYLOAD: max_payload_q <= cfg_data;
				CFG_MAX_LINE:    max_line_q    <= cfg_data[7:0];
				default:         max_payload_q <= max_payload_q;
			endcase
		end
	end

	bgfp_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_valid),
		.push_data (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign kind         = out_data.kind;
	assign msg_class    = out_data.msg_class;
	assign msg_id       = out_data.msg_id;
	assign data_byte    = out_data.data_byte;
	assign byte_index   = out_data.byte_index;
	assign frame_length = out_data.frame_length;
	assign frame_status = out_data.frame_status;
	assign last         = out_data.last;

`ifndef SYNTHESIS
	a_payload_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == PH_PAYLOAD) |=> out_valid)
		else $error("payload byte transfer produced no result");

	a_ckb_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == PH_CK_B) |=> (phase_q == PH_IDLE && out_valid))
		else $error("checksum byte did not close the frame");

	a_pos_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (pos_q < length_q && length_q <= max_payload_q))
		else $error("payload position out of frame bounds");
`endif

endmodule

// ===== sim/bgfp_frame_checker.sv =====
// Scoreboard for the binary GNSS frame parser: tracks frame phase, checksum and limits.
// Watches both channels and register writes; depends on bgfp_pkg.
module bgfp_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        kind,
	input  logic [7:0]  msg_class,
	input  logic [7:0]  msg_id,
	input  logic [7:0]  data_byte,
	input  logic [15:0] byte_index,
	input  logic [15:0] frame_length,
	input  logic [1:0]  frame_status,
	input  logic        last,
	output int          errors,
	output int          results_checked,
	output int          pending = 0,
	output logic        parse_idle = 1'b1
);
	import bgfp_pkg::*;

	logic [15:0] lim_payload;
	logic [7:0]  lim_line;

	phase_t      phase;
	logic [7:0]  line_cnt;
	logic [7:0]  cur_class;
	logic [7:0]  cur_id;
	logic [15:0] cur_len;
	logic [15:0] cur_pos;
	logic [7:0]  fl_a;
	logic [7:0]  fl_b;
	logic [7:0]  rx_ck_a;

	result_t     due_results[$];
	result_t     seen;
	int          n_err = 0;
	int          n_seen = 0;

	assign errors = n_err;
	assign results_checked = n_seen;

	task automatic flag_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		n_err++;
		$display("[%0t] mismatch, %s: got %0h, expected %0h", $realtime, what, got, want);
	endtask

	function automatic void fletcher_add(input logic [7:0] b);
		fl_a = fl_a + b;
		fl_b = fl_b + fl_a;
	endfunction

	function automatic result_t frame_report(input logic [1:0] st);
		result_t r;
		r = '0;
		r.kind = KIND_REPORT;
		r.msg_class = cur_class;
		r.msg_id = cur_id;
		r.frame_length = cur_len;
		r.frame_status = st;
		r.last = 1'b1;
		return r;
	endfunction

	task automatic parse_rx_byte(input logic [7:0] b);
		result_t r;
		r = '0;
		case (phase)
			PH_LINE: begin
				if (b == TEXT_END) begin
					line_cnt = '0;
					phase = PH_IDLE;
				end else begin
					line_cnt = line_cnt + 8'd1;
					if (line_cnt >= lim_line || line_cnt < 8'd2) begin
						line_cnt = '0;
						phase = PH_IDLE;
					end
				end
			end
			PH_SYNC2: begin
				if (b == SYNC_SECOND) begin
					fl_a = '0;
					fl_b = '0;
					phase = PH_CLASS;
				end else begin
					phase = PH_IDLE;
				end
			end
			PH_CLASS: begin
				cur_class = b;
				fletcher_add(b);
				phase = PH_ID;
			end
			PH_ID: begin
				cur_id = b;
				fletcher_add(b);
				phase = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				cur_len = {8'h00, b};
				fletcher_add(b);
				phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				cur_len = {b, cur_len[7:0]};
				fletcher_add(b);
				cur_pos = '0;
				if (cur_len > lim_payload) begin
					due_results.push_back(frame_report(STATUS_TOO_LONG));
					phase = PH_IDLE;
				end else if (cur_len == 16'd0) begin
					phase = PH_CK_A;
				end else begin
					phase = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				r.kind = KIND_PAYLOAD;
				r.msg_class = cur_class;
				r.msg_id = cur_id;
				r.data_byte = b;
				r.byte_index = cur_pos;
				r.frame_length = cur_len;
				r.frame_status = STATUS_OK;
				due_results.push_back(r);
				fletcher_add(b);
				cur_pos = cur_pos + 16'd1;
				if (cur_pos >= cur_len)
					phase = PH_CK_A;
			end
			PH_CK_A: begin
				rx_ck_a = b;
				phase = PH_CK_B;
			end
			PH_CK_B: begin
				due_results.push_back(frame_report(
					(rx_ck_a == fl_a && b == fl_b) ? STATUS_OK : STATUS_BAD_CK));
				phase = PH_IDLE;
			end
			default: begin
				phase = PH_IDLE;
				if (b == TEXT_START) begin
					line_cnt = 8'd1;
					phase = PH_LINE;
				end else if (b == SYNC_FIRST) begin
					phase = PH_SYNC2;
				end
			end
		endcase
	endtask

	task automatic compare_result(input result_t got);
		result_t want;
		n_seen++;
		if (due_results.size() == 0) begin
			flag_mismatch("result with nothing outstanding", 16'(got.data_byte), 16'h0);
		end else begin
			want = due_results.pop_front();
			if (got.kind !== want.kind)
				flag_mismatch("kind", 16'(got.kind), 16'(want.kind));
			if (got.msg_class !== want.msg_class)
				flag_mismatch("msg_class", 16'(got.msg_class), 16'(want.msg_class));
			if (got.msg_id !== want.msg_id)
				flag_mismatch("msg_id", 16'(got.msg_id), 16'(want.msg_id));
			if (got.data_byte !== want.data_byte)
				flag_mismatch("data_byte", 16'(got.data_byte), 16'(want.data_byte));
			if (got.byte_index !== want.byte_index)
				flag_mismatch("byte_index", got.byte_index, want.byte_index);
			if (got.frame_length !== want.frame_length)
				flag_mismatch("frame_length", got.frame_length, want.frame_length);
			if (got.frame_status !== want.frame_status)
				flag_mismatch("frame_status", 16'(got.frame_status),
					16'(want.frame_status));
			if (got.last !== want.last)
				flag_mismatch("last", 16'(got.last), 16'(want.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_payload = MAX_PAYLOAD_RESET;
			lim_line = MAX_LINE_RESET;
			phase = PH_IDLE;
			line_cnt = '0;
			cur_class = '0;
			cur_id = '0;
			cur_len = '0;
			cur_pos = '0;
			fl_a = '0;
			fl_b = '0;
			rx_ck_a = '0;
			due_results.delete();
			pending <= 0;
			parse_idle <= 1'b1;
		end else begin
			// outputs are registered, so check them before taking this cycle's byte
			if (out_valid && out_ready) begin
				seen = {kind, msg_class, msg_id, data_byte, byte_index,
					frame_length, frame_status, last};
				compare_result(seen);
			end
			if (in_valid && in_ready)
				parse_rx_byte(rx_byte);
			// a register write applies from the next byte on
			if (cfg_we) begin
				case (cfg_index)
					CFG_MAX_PAYLOAD: lim_payload = cfg_data;
					CFG_MAX_LINE:    lim_line = cfg_data[7:0];
					default:         lim_payload = lim_payload;
				endcase
			end
			pending <= due_results.size();
			parse_idle <= (phase == PH_IDLE);
		end
	end

endmodule

// ===== sim/tb_binary_gnss_frame_parser_core.sv =====
// Testbench top for binary_gnss_frame_parser_core: clock, reset, byte stimulus, verdict.
// Depends on bgfp_pkg, binary_gnss_frame_parser_core and bgfp_frame_checker.
module tb_binary_gnss_frame_parser_core;
	import bgfp_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE       = 6;
	localparam int SEGMENT_SIZE = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_MAX_PAYLOAD;
	logic [15:0] cfg_data = 16'h0000;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        kind;
	logic [7:0]  msg_class;
	logic [7:0]  msg_id;
	logic [7:0]  data_byte;
	logic [15:0] byte_index;
	logic [15:0] frame_length;
	logic [1:0]  frame_status;
	logic        last;

	int          errors;
	int          results_checked;
	int          pending;
	logic        parse_idle;

	// idle percentages for each side, switched between stimulus segments
	int          send_gap_pct = 38;
	int          recv_stall_pct = 76;

	// limits as last written, used to shape frame and line lengths
	int          cur_pay_lim = MAX_PAYLOAD_RESET;
	int          cur_line_lim = MAX_LINE_RESET;

	int          n_bytes = 0;
	int          n_frames = 0;
	int          n_cycles = 0;
	int          seg_start;

	// register settings per random segment: zero and full-scale limits, and
	// line limits below two, where a line ends after its first character
	int          seg_pay[6]  = '{16, 0, 65535, 7, 1, 300};
	int          seg_line[6] = '{2, 1, 255, 0, 128, 40};

	binary_gnss_frame_parser_core dut (.*);

	bgfp_frame_checker chk (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	// Stall the result channel at random; the rate follows the current segment.
	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", n_cycles, pending);
			$display("simulation failed");
			$finish;
		end
	end

	// Offer one byte, with random gaps ahead of it, and hold it until the transfer.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		n_bytes++;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Hold the sender off until every predicted result has been taken, then
	// let the core settle on bytes that produce nothing.
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Feed zero bytes until the parser sits in idle: they end lines, finish
	// payloads and close frames without starting anything new.
	task automatic flush_to_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (!parse_idle) begin
			send_byte(8'h00);
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic set_register(input logic idx, input logic [15:0] value);
		flush_to_idle();
		wait_results_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MAX_PAYLOAD)
			cur_pay_lim = int'(value);
		else
			cur_line_lim = int'(value[7:0]);
	endtask

	// Send a binary frame. A payload cut short lets whatever follows run on as
	// payload; a length over the limit sends the header only, since the core
	// abandons the frame right after the length bytes.
	task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
			input logic [15:0] len, input bit corrupt, input int cut);
		logic [7:0] ck_a;
		logic [7:0] ck_b;
		logic [7:0] d;
		logic [7:0] hdr[4];
		int         i;
		ck_a = '0;
		ck_b = '0;
		hdr = '{cls, id, len[7:0], len[15:8]};
		n_frames++;
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		for (i = 0; i < 4; i++) begin
			ck_a = ck_a + hdr[i];
			ck_b = ck_b + ck_a;
			send_byte(hdr[i]);
		end
		if (len > cur_pay_lim)
			return;
		for (i = 0; i < len && i < cut; i++) begin
			d = 8'($urandom_range(0, 255));
			ck_a = ck_a + d;
			ck_b = ck_b + ck_a;
			send_byte(d);
		end
		if (cut < len)
			return;
		if (corrupt) begin
			if ($urandom_range(0, 1))
				ck_a = ck_a ^ (8'h01 << $urandom_range(0, 7));
			else
				ck_b = ck_b ^ (8'h01 << $urandom_range(0, 7));
		end
		send_byte(ck_a);
		send_byte(ck_b);
	endtask

	// Text line: '$', n characters of any value, and optionally a newline.
	task automatic send_line(input int n, input bit with_newline);
		send_byte(TEXT_START);
		repeat (n) send_byte(8'($urandom_range(0, 255)));
		if (with_newline)
			send_byte(TEXT_END);
	endtask

	// Mostly short payloads; some right around the limit, some well over it.
	function automatic logic [15:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return 16'($urandom_range(0, 12));
		if (r < 90 && cur_pay_lim <= 300)
			return 16'($urandom_range((cur_pay_lim == 0) ? 0 : cur_pay_lim - 1,
				cur_pay_lim + 1));
		if (cur_pay_lim < 65535)
			return 16'($urandom_range(cur_pay_lim + 1, 65535));
		return 16'($urandom_range(0, 12));
	endfunction

	function automatic int pick_line_length();
		if ($urandom_range(0, 99) < 70)
			return $urandom_range(0, 8);
		return $urandom_range((cur_line_lim < 2) ? 0 : cur_line_lim - 2, cur_line_lim + 2);
	endfunction

	// One random sequence: well-formed frames dominate, the rest is text,
	// broken sync, truncated frames, noise and the occasional full pause.
	task automatic random_sequence();
		int         r;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				pick_length(), $urandom_range(0, 99) < 15, 1 << 30);
		end else if (r < 70) begin
			send_line(pick_line_length(), $urandom_range(0, 99) < 60);
		end else if (r < 80) begin
			do
				b = 8'($urandom_range(0, 255));
			while (b == SYNC_SECOND);
			send_byte(SYNC_FIRST);
			send_byte(b);
		end else if (r < 85) begin
			send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				16'($urandom_range(2, 12)), 1'b0, $urandom_range(0, 1));
		end else if (r < 96) begin
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
		end else begin
			wait_results_drained();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset limits: newline-ended text line, wrong second
		// sync byte, zero-length frame, bad checksum, length one over the limit,
		// and bytes that idle simply drops.
		send_line(1, 1'b1);
		send_byte(SYNC_FIRST);
		send_byte(8'h00);
		send_frame(8'h01, 8'h07, 16'd0, 1'b0, 1 << 30);
		send_frame(8'hFF, 8'h00, 16'd1, 1'b1, 1 << 30);
		send_frame(8'h06, 8'h01, MAX_PAYLOAD_RESET + 16'd1, 1'b0, 1 << 30);
		send_byte(8'hFF);
		send_byte(8'h00);
		// pause the sender until everything is back before going random
		wait_results_drained();

		for (int seg = 0; seg < 6; seg++) begin
			set_register(CFG_MAX_PAYLOAD, 16'(seg_pay[seg]));
			set_register(CFG_MAX_LINE, 16'(seg_line[seg]));
			// first the sender gaps lightly and the receiver heavily, then the
			// reverse, then back to back
			case (seg / 2)
				0: begin
					send_gap_pct = 38;
					recv_stall_pct = 76;
				end
				1: begin
					send_gap_pct = 76;
					recv_stall_pct = 38;
				end
				default: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			seg_start = n_bytes;
			while (n_bytes - seg_start < SEGMENT_SIZE)
				random_sequence();
		end

		// drain everything, with an extra margin for bytes that produce nothing
		wait_results_drained();
		repeat (2 * SETTLE) @(posedge clk);

		$display("covered %0d input bytes and %0d frame starts; %0d results checked",
			n_bytes, n_frames, results_checked);
		$display("limits ran from zero to full scale under three handshake patterns");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
